// File: rtl/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

  // table geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // port field widths
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int TOT_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;        // capture compare flags against the key
    logic ins;        // insert shift cycle
    logic rem;        // remove shift cycle
    logic live;       // cell index below entry count
    logic at_count;   // cell index equals entry count
    logic next_live;  // right neighbor is live
    logic del_from;   // cell index at or above removal position
    logic left_gt;    // left neighbor holds a value above the key
  } cell_ctl_t;

endpackage

// File: rtl/sat_if.sv
`timescale 1ns / 1ps

interface sat_cmd_if;
  import sat_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [VAL_W-1:0]  operand_value;

  modport source (output valid, command, operand_value, input ready);
  modport sink   (input valid, command, operand_value, output ready);
endinterface

interface sat_res_if;
  import sat_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [TOT_W-1:0]  entry_total;

  modport source (output valid, status, position, entry_total, input ready);
  modport sink   (input valid, status, position, entry_total, output ready);
endinterface

// File: rtl/sat_cell.sv
`timescale 1ns / 1ps

module sat_cell
  import sat_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] key,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  output logic signed [VAL_W-1:0] value,
  output logic                    gt,
  output logic                    eq
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      gt <= ctl.live && (value > key);
      eq <= ctl.live && (value == key);
    end
    if (ctl.ins) begin
      // larger entries move up one place, the key drops into the gap
      if (ctl.left_gt) begin
        value <= left_value;
      end else if (gt || ctl.at_count) begin
        value <= key;
      end
    end else if (ctl.rem) begin
      if (ctl.del_from && ctl.next_live) begin
        value <= right_value;
      end
    end
  end

endmodule

// File: rtl/sorted_array_table.sv
`timescale 1ns / 1ps

// channel  dir  payload                              request accepted
// cmd      in   command, operand_value               cmd.valid && cmd.ready
// res      out  status, position, entry_total        res.valid && res.ready
//
// one request at a time: accept, compare, search for search and remove (up
// to log2(CAPACITY)+1 probes, then one closing check on a miss), one shift
// for insert (none when full) and remove, one load of the result register,
// which waits while res is stalled on an earlier result.
// rst clears the count, the sequencer and the result valid; cell values
// are not reset. a result held by a stalled res waits in its register.

module sorted_array_table
  import sat_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sat_cmd_if.sink      cmd,
  sat_res_if.source    res
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hx;      // exclusive upper bound of the search window
  logic [IDX_W-1:0]        pos_q;
  logic [STAT_W-1:0]       status_q;

  logic                    res_valid;
  logic [STAT_W-1:0]       res_status;
  logic [POS_W-1:0]        res_position;
  logic [TOT_W-1:0]        res_total;

  // cell row
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     gt_v;
  logic [CAPACITY-1:0]     eq_v;

  logic [CNT_W-1:0]        mid_w;
  logic [IDX_W-1:0]        mid;

  // midpoint low + (high - low) / 2, with high = hx - 1
  assign mid_w = lo + ((hx - CNT_W'(1) - lo) >> 1);
  assign mid   = mid_w[IDX_W-1:0];

  assign cmd.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.position    = res_position;
  assign res.entry_total = res_total;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctl_t               ctl;
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;

      // edge cells see themselves as the missing neighbor
      if (i == 0) begin : g_first
        assign ctl.left_gt = 1'b0;
        assign left_value  = cell_val[i];
      end else begin : g_mid_left
        assign ctl.left_gt = gt_v[i-1];
        assign left_value  = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_value = cell_val[i];
      end else begin : g_mid_right
        assign right_value = cell_val[i+1];
      end

      assign ctl.cmp       = (state == S_CMP);
      assign ctl.ins       = (state == S_SHIFT) && (cmd_q == CMD_INSERT);
      assign ctl.rem       = (state == S_SHIFT) && (cmd_q == CMD_REMOVE);
      assign ctl.live      = CNT_W'(i) < count;
      assign ctl.at_count  = CNT_W'(i) == count;
      assign ctl.next_live = CNT_W'(i + 1) < count;
      assign ctl.del_from  = IDX_W'(i) >= pos_q;

      sat_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .key         (key_q),
        .left_value  (left_value),
        .right_value (right_value),
        .value       (cell_val[i]),
        .gt          (gt_v[i]),
        .eq          (eq_v[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // result taken downstream, unless S_DONE loads the next one
      if (res.valid && res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q    <= cmd.command;
            key_q    <= cmd.operand_value;
            pos_q    <= '0;
            status_q <= ST_MISS;
            state    <= S_CMP;
          end
        end

        S_CMP: begin
          // cells latch their flags this cycle
          lo <= '0;
          hx <= count;
          priority if (cmd_q == CMD_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              status_q <= ST_FULL;
              state    <= S_DONE;
            end else begin
              state <= S_SHIFT;
            end
          end else if (cmd_q == CMD_SEARCH || cmd_q == CMD_REMOVE) begin
            state <= S_SRCH;
          end else begin
            // unused code: no change, reported as a miss
            state <= S_DONE;
          end
        end

        S_SRCH: begin
          priority if (lo >= hx) begin
            state <= S_DONE;
          end else if (eq_v[mid]) begin
            pos_q <= mid;
            if (cmd_q == CMD_REMOVE) begin
              state <= S_SHIFT;
            end else begin
              status_q <= ST_OK;
              state    <= S_DONE;
            end
          end else if (gt_v[mid]) begin
            hx <= mid_w;
          end else begin
            lo <= mid_w + CNT_W'(1);
          end
        end

        S_SHIFT: begin
          // cells move their values this cycle
          if (cmd_q == CMD_INSERT) begin
            count <= count + CNT_W'(1);
          end else begin
            count <= count - CNT_W'(1);
          end
          status_q <= ST_OK;
          state    <= S_DONE;
        end

        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid    <= 1'b1;
            res_status   <= status_q;
            res_position <= POS_W'(pos_q);
            res_total    <= TOT_W'(count);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
